@@ rtl/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes for the sorted key table
// Operation and status codes, default sizes and the command word that is
// broadcast to every cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned TAG_BITS_DEF = 32;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned IN_TAG_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned OUT_TAG_W = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOTFOUND  = 3'd4,
    ST_FOUND     = 3'd5
  } status_t;

  // Command broadcast along the chain for one transaction
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [KEY_W-1:0]  key;
  } skt_cmd_t;

endpackage

`default_nettype wire

@@ rtl/skt_cell.sv @@
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key chain
// Holds one key and tag, compares the key against the probe key and on an
// insert or delete either keeps its entry, takes the new one, or takes the
// entry of its left or right neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell #(
  parameter int unsigned TAG_BITS = skt_pkg::TAG_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire skt_pkg::skt_cmd_t                 cmd,
  input  wire logic [TAG_BITS-1:0]               new_tag,
  input  wire logic                              valid,
  input  wire logic                              left_lt,
  input  wire logic signed [skt_pkg::KEY_W-1:0]  left_key,
  input  wire logic [TAG_BITS-1:0]               left_tag,
  input  wire logic signed [skt_pkg::KEY_W-1:0]  right_key,
  input  wire logic [TAG_BITS-1:0]               right_tag,
  output logic signed [skt_pkg::KEY_W-1:0]       key,
  output logic [TAG_BITS-1:0]                    tag,
  output logic                                   lt,
  output logic                                   eq
);

  assign lt = valid && (key < cmd.key);
  assign eq = valid && (key == cmd.key);

  // On an insert or delete, entries below the probe hold; the rest move one place
  always_ff @(posedge clk) begin
    if (cmd.ins && !lt) begin
      if (left_lt) begin
        key <= cmd.key;
        tag <= new_tag;
      end else begin
        key <= left_key;
        tag <= left_tag;
      end
    end else if (cmd.del && !lt) begin
      key <= right_key;
      tag <= right_tag;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sorted_key_table_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_unit: sorted table of unique signed keys with name tags
// Input transactions arrive on the s_ channel: s_tuser carries the operation
// (insert, delete, search), s_tdata the key and the tag. Each transaction
// gives exactly one result on the m_ channel: status, 1-based position and
// tag of a found key. The table is a chain of CAPACITY cells; every cell
// compares its key with the probe in parallel and an insert or delete shifts
// the chain by one place in the same cycle, and its result is registered:
// one item per cycle sustained while the receiver does not stall the result.
// The rate is set by the broadcast compare and the shift of the chain.
// The result register parts the two sides: a new transaction is taken while
// the held result is taken in the same cycle; while the receiver stalls, the
// result holds and s_tready is low. Reset empties the table (entry count zero),
// holds s_tready low and drops any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_unit #(
  parameter int unsigned CAPACITY = skt_pkg::CAPACITY_DEF,
  parameter int unsigned TAG_BITS = skt_pkg::TAG_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // key[31:0], tag[63:32]
  input  wire logic [1:0]  s_tuser,   // kind[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // status[2:0], position[7:3], found_tag[39:8]
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = skt_pkg::KEY_W;

  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic                  s_fire;
  skt_pkg::skt_cmd_t     cmd;
  skt_pkg::kind_t        kind;
  logic [TAG_BITS+skt_pkg::IN_TAG_W-1:0] tag_ext;
  logic [TAG_BITS-1:0]   new_tag;

  logic signed [KW-1:0]  cell_key [CAPACITY];
  logic [TAG_BITS-1:0]   cell_tag [CAPACITY];
  logic [CAPACITY-1:0]   lt_vec;
  logic [CAPACITY-1:0]   eq_vec;
  logic [CAPACITY-1:0]   valid_vec;

  logic                  hit;
  logic                  full;
  logic [CW-1:0]         pos_wide;
  logic [CW+skt_pkg::POS_W-1:0] pos_ext;
  logic [TAG_BITS-1:0]   hit_tag;
  logic [TAG_BITS+skt_pkg::OUT_TAG_W-1:0] hit_tag_ext;
  skt_pkg::status_t      res_status;
  logic [skt_pkg::POS_W-1:0]     res_pos;
  logic [skt_pkg::OUT_TAG_W-1:0] res_tag;

  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign s_fire   = s_tvalid && s_tready;
  assign kind     = skt_pkg::kind_t'(s_tuser);

  assign tag_ext  = {{TAG_BITS{1'b0}}, s_tdata[63:32]};
  assign new_tag  = tag_ext[TAG_BITS-1:0];

  assign hit  = |eq_vec;
  assign full = (count == CW'(CAPACITY));

  assign cmd.key = s_tdata[KW-1:0];
  assign cmd.ins = s_fire && (kind == skt_pkg::KIND_INSERT) && !hit && !full;
  assign cmd.del = s_fire && (kind == skt_pkg::KIND_DELETE) && hit;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                 left_lt_i;
      logic signed [KW-1:0] left_key_i;
      logic [TAG_BITS-1:0]  left_tag_i;
      logic signed [KW-1:0] right_key_i;
      logic [TAG_BITS-1:0]  right_tag_i;

      assign valid_vec[gi] = (CW'(gi) < count);

      if (gi == 0) begin : g_first
        assign left_lt_i  = 1'b1;
        assign left_key_i = cmd.key;
        assign left_tag_i = new_tag;
      end else begin : g_mid
        assign left_lt_i  = lt_vec[gi-1];
        assign left_key_i = cell_key[gi-1];
        assign left_tag_i = cell_tag[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        // Vacated slot beyond the count: contents are never read
        assign right_key_i = cell_key[gi];
        assign right_tag_i = cell_tag[gi];
      end else begin : g_inner
        assign right_key_i = cell_key[gi+1];
        assign right_tag_i = cell_tag[gi+1];
      end

      skt_cell #(
        .TAG_BITS (TAG_BITS)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .new_tag   (new_tag),
        .valid     (valid_vec[gi]),
        .left_lt   (left_lt_i),
        .left_key  (left_key_i),
        .left_tag  (left_tag_i),
        .right_key (right_key_i),
        .right_tag (right_tag_i),
        .key       (cell_key[gi]),
        .tag       (cell_tag[gi]),
        .lt        (lt_vec[gi]),
        .eq        (eq_vec[gi])
      );
    end
  endgenerate

  // At most one cell matches: plain OR of the selected position and tag
  always_comb begin
    pos_wide = '0;
    hit_tag  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq_vec[i]) begin
        pos_wide = pos_wide | CW'(i + 1);
        hit_tag  = hit_tag | cell_tag[i];
      end
    end
  end

  assign pos_ext     = {{skt_pkg::POS_W{1'b0}}, pos_wide};
  assign hit_tag_ext = {{skt_pkg::OUT_TAG_W{1'b0}}, hit_tag};

  always_comb begin
    res_pos    = '0;
    res_tag    = '0;
    count_next = count;
    case (kind)
      skt_pkg::KIND_INSERT: begin
        if (hit) begin
          res_status = skt_pkg::ST_DUPLICATE;
        end else if (full) begin
          res_status = skt_pkg::ST_FULL;
        end else begin
          res_status = skt_pkg::ST_INSERTED;
          count_next = count + CW'(1);
        end
      end
      skt_pkg::KIND_DELETE: begin
        if (hit) begin
          res_status = skt_pkg::ST_DELETED;
          count_next = count - CW'(1);
        end else begin
          res_status = skt_pkg::ST_NOTFOUND;
        end
      end
      skt_pkg::KIND_SEARCH: begin
        if (hit) begin
          res_status = skt_pkg::ST_FOUND;
          res_pos    = pos_ext[skt_pkg::POS_W-1:0];
          res_tag    = hit_tag_ext[skt_pkg::OUT_TAG_W-1:0];
        end else begin
          res_status = skt_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        res_status = skt_pkg::ST_NOTFOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= {res_tag, res_pos, res_status};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_unique_keys: assert property (@(posedge clk) disable iff (rst)
    $onehot0(eq_vec))
    else $error("more than one cell matches the probe key");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the table");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.del |=> count == $past(count) - CW'(1))
    else $error("delete did not shrink the table");

  a_sorted_prefix: assert property (@(posedge clk) disable iff (rst)
    (lt_vec & ~valid_vec) == '0 && ((lt_vec >> 1) & ~lt_vec) == '0)
    else $error("cells below the probe key do not form a prefix");

endmodule

`default_nettype wire
